// File: design/hcbd_pkg.sv
`timescale 1ns / 1ps

package hcbd_pkg;

    // Size line: characters parsed per line, and width of the chunk size.
    localparam int LINE_CHARS = 31;
    localparam int SIZE_BITS  = 32;
    localparam int LINE_CNT_W = $clog2(LINE_CHARS + 1);
    localparam int RADIX      = 16;
    localparam int DIGIT_BITS = $clog2(RADIX);

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,  // skipping leading blanks
        PH_DIGITS = 2'd1,  // reading hex digits
        PH_STOP   = 2'd2   // rest of the line ignored
    } hcbd_phase_t;

    typedef struct packed {
        logic                  in_size_line;
        logic [SIZE_BITS-1:0]  left_in_chunk;
        logic [SIZE_BITS-1:0]  size_value;
        hcbd_phase_t           digit_phase;
        logic [LINE_CNT_W-1:0] line_count;
        logic                  saw_last;
    } hcbd_state_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f"))
            || ((c >= "A") && (c <= "F"));
        return r;
    endfunction

    function automatic logic [DIGIT_BITS-1:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= "0") && (c <= "9"))
        begin
            v = c - 8'("0");
        end
        else if ((c >= "a") && (c <= "f"))
        begin
            v = c - 8'("a") + 8'd10;
        end
        else
        begin
            v = c - 8'("A") + 8'd10;
        end
        return v[DIGIT_BITS-1:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        logic r;
        r = (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
        return r;
    endfunction

endpackage

// File: design/http_chunked_body_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Word
// -------   ---  -------------------  -------------------------------------
// in        in   in_valid/in_ready    in_byte: one raw byte of the reply body
// out       out  out_valid/out_ready  body_byte, body_valid, finished
// cfg       in   cfg_valid/cfg_ready  cfg_data: chunked_mode
//
// One word in, one word out, one word per cycle sustained while out_ready is high. The decoder state
// and the output register both load at the edge that accepts a word, so the
// result is offered from the next cycle on. Its critical path is the 32-bit
// chunk counter decrement or the saturating size accumulate. in_ready drops
// only while the output register is full and out_ready is low. cfg is always
// ready. rst_n clears the mode, the decoder state and the output valid.
module http_chunked_body_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] body_byte,
    output logic       body_valid,
    output logic       finished,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import hcbd_pkg::*;

    logic        chunked_mode_reg;
    hcbd_state_t state_reg;
    hcbd_state_t state_next;
    hcbd_state_t step_state;
    logic        step_valid;
    logic        accept;
    logic        word_valid;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  body_byte_reg;
    logic        body_valid_reg;
    logic        finished_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // Chunked framing logic for the incoming word.
    hcbd_step u_step (
        .state_in   (state_reg),
        .data_byte  (in_byte),
        .state_out  (step_state),
        .byte_valid (step_valid)
    );

    // Pass-through mode leaves the framing state alone.
    always_comb
    begin
        if (chunked_mode_reg)
        begin
            state_next = step_state;
            word_valid = step_valid;
        end
        else
        begin
            state_next = state_reg;
            word_valid = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunked_mode_reg <= 1'b0;
            state_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                chunked_mode_reg <= cfg_data;
            end
            if (accept)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: no reset needed, qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            body_byte_reg  <= word_valid ? in_byte : 8'h00;
            body_valid_reg <= word_valid;
            finished_reg   <= state_next.saw_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign body_byte  = body_byte_reg;
    assign body_valid = body_valid_reg;
    assign finished   = finished_reg;

    // A dropped body byte must read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !body_valid_reg) |-> (body_byte_reg == 8'h00))
        else $error("non-body word carries a nonzero byte");

    // Once the last chunk is seen it stays seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.saw_last |=> state_reg.saw_last)
        else $error("saw_last cleared without reset");

    // The chunk counter moves only on an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg.left_in_chunk))
        else $error("left_in_chunk changed without a word");

    // The line counter never runs past the parsed prefix.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line_count <= LINE_CNT_W'(LINE_CHARS))
        else $error("line_count past line limit");

    // Every accepted word produces a result the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word lost");

endmodule

// File: design/hcbd_step.sv
`timescale 1ns / 1ps

// Next decoder state for one byte in chunked mode.
module hcbd_step (
    input  hcbd_pkg::hcbd_state_t state_in,
    input  logic [7:0]            data_byte,
    output hcbd_pkg::hcbd_state_t state_out,
    output logic                  byte_valid
);
    import hcbd_pkg::*;

    logic                 digit_ok;
    logic [DIGIT_BITS-1:0] digit;
    logic [SIZE_BITS-1:0] accum;
    logic                 is_crlf;

    assign digit_ok = is_hex(data_byte);
    assign digit    = hex_digit(data_byte);
    assign is_crlf  = (data_byte == CH_CR) || (data_byte == CH_LF);

    // Saturating size * 16 + digit: any bit in the top nibble overflows.
    always_comb
    begin
        if (state_in.size_value[SIZE_BITS-1 -: DIGIT_BITS] != '0)
        begin
            accum = '1;
        end
        else
        begin
            accum = {state_in.size_value[SIZE_BITS-DIGIT_BITS-1:0], digit};
        end
    end

    always_comb
    begin
        state_out  = state_in;
        byte_valid = 1'b0;
        if (state_in.saw_last)
        begin
            state_out = state_in;
        end
        else if (state_in.in_size_line || ((state_in.left_in_chunk == '0) && !is_crlf))
        begin
            state_out.in_size_line = 1'b1;
            if (data_byte == CH_LF)
            begin
                state_out.left_in_chunk = state_in.size_value;
                state_out.in_size_line  = 1'b0;
                state_out.size_value    = '0;
                state_out.digit_phase   = PH_BLANK;
                state_out.line_count    = '0;
                if (state_in.size_value == '0)
                begin
                    state_out.saw_last = 1'b1;
                end
            end
            else if ((data_byte != CH_CR) && (state_in.line_count < LINE_CNT_W'(LINE_CHARS)))
            begin
                state_out.line_count = state_in.line_count + LINE_CNT_W'(1);
                case (state_in.digit_phase)
                    PH_BLANK:
                    begin
                        if (!is_blank(data_byte))
                        begin
                            if (digit_ok)
                            begin
                                state_out.digit_phase = PH_DIGITS;
                                state_out.size_value  = SIZE_BITS'(digit);
                            end
                            else
                            begin
                                state_out.digit_phase = PH_STOP;
                            end
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (digit_ok)
                        begin
                            state_out.size_value = accum;
                        end
                        else
                        begin
                            state_out.digit_phase = PH_STOP;
                        end
                    end
                    default:
                    begin
                        state_out.digit_phase = state_in.digit_phase;
                    end
                endcase
            end
        end
        else if (state_in.left_in_chunk != '0)
        begin
            byte_valid              = 1'b1;
            state_out.left_in_chunk = state_in.left_in_chunk - SIZE_BITS'(1);
        end
    end

endmodule

// File: dv/http_chunked_body_decoder_tb.sv
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
    import hcbd_pkg::*;

    localparam int   CLK_HALF     = 6;
    localparam int   IDLE_PCT     = 29;
    localparam int   STALL_LIMIT  = 1000;
    localparam int   MAX_REPORTS  = 10;
    localparam int   RANDOM_ITEMS = 330;
    localparam logic MODE_PASS    = 1'b0;
    localparam logic MODE_CHUNKED = 1'b1;

    // One output word of the decoder.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       finished;
    } body_word_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] body_byte;
    logic       body_valid;
    logic       finished;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // Decoder state as the checker sees it; all of it starts cleared, as the DUT is at reset.
    logic                  chunked_on = 1'b0;
    logic                  in_line    = 1'b0;
    logic [SIZE_BITS-1:0]  chunk_left = '0;
    logic [SIZE_BITS-1:0]  line_value = '0;
    hcbd_phase_t           line_phase = PH_BLANK;
    logic [LINE_CNT_W-1:0] line_chars = '0;
    logic                  body_done  = 1'b0;

    // Decoded words still owed by the DUT, oldest first.
    body_word_t decoded_q[$];

    int    mismatches   = 0;
    int    words_in     = 0;
    int    words_out    = 0;
    int    payload_seen = 0;
    int    stall_cycles = 0;
    int    sent_words   = 0;
    int    gap_words    = 0;
    int    chunks_sent  = 0;
    int    mode_writes  = 0;
    bit    steady       = 1'b0;
    string ending       = "none";

    http_chunked_body_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .body_byte (body_byte),
        .body_valid(body_valid),
        .finished  (finished),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // {not_hex, value} of one character; hex digits of either case.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [7:0] v;
        logic [4:0] r;
        r = 5'h10;
        if ((c >= "0") && (c <= "9"))
        begin
            v = c - "0";
            r = {1'b0, v[3:0]};
        end
        else if ((c >= "a") && (c <= "f"))
        begin
            v = c - "a" + 8'd10;
            r = {1'b0, v[3:0]};
        end
        else if ((c >= "A") && (c <= "F"))
        begin
            v = c - "A" + 8'd10;
            r = {1'b0, v[3:0]};
        end
        return r;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
    endfunction

    // Append one hex digit to the size, pinned at all ones on overflow.
    function automatic void push_digit(input logic [3:0] d);
        logic [SIZE_BITS+3:0] grown;
        grown = ({4'b0000, line_value} << 4) | {{SIZE_BITS{1'b0}}, d};
        if (grown[SIZE_BITS+3:SIZE_BITS] != 4'b0000)
            line_value = '1;
        else
            line_value = grown[SIZE_BITS-1:0];
    endfunction

    // One character of a chunk-size line.
    function automatic void take_line_char(input logic [7:0] c);
        logic [4:0] hx;
        hx = hex_of(c);
        if (c == CH_LF)
        begin
            chunk_left = line_value;
            in_line    = 1'b0;
            line_value = '0;
            line_phase = PH_BLANK;
            line_chars = '0;
            if (chunk_left == '0)
                body_done = 1'b1;
        end
        else if ((c != CH_CR) && (line_chars < LINE_CNT_W'(LINE_CHARS)))
        begin
            line_chars = line_chars + LINE_CNT_W'(1);
            case (line_phase)
                PH_BLANK:
                begin
                    if (!blank_char(c))
                    begin
                        if (!hx[4])
                        begin
                            line_phase = PH_DIGITS;
                            line_value = {{(SIZE_BITS-4){1'b0}}, hx[3:0]};
                        end
                        else
                        begin
                            line_phase = PH_STOP;
                        end
                    end
                end
                PH_DIGITS:
                begin
                    if (!hx[4])
                        push_digit(hx[3:0]);
                    else
                        line_phase = PH_STOP;
                end
                default: ;   // stopped: rest of the line is ignored
            endcase
        end
    endfunction

    // Decoded word for one accepted input byte; advances the state.
    function automatic body_word_t decode_byte(input logic [7:0] c);
        body_word_t w;
        logic       pass;
        pass = 1'b0;
        if (!chunked_on)
            pass = 1'b1;
        else if (body_done)
            pass = 1'b0;
        else if (in_line)
            take_line_char(c);
        else if (chunk_left == '0)
        begin
            // between chunks CR/LF are skipped, anything else opens a line
            if ((c != CH_CR) && (c != CH_LF))
            begin
                in_line = 1'b1;
                take_line_char(c);
            end
        end
        else
        begin
            pass       = 1'b1;
            chunk_left = chunk_left - SIZE_BITS'(1);
        end
        w.body_byte  = pass ? c : 8'h00;
        w.body_valid = pass;
        w.finished   = body_done;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, sampled at the rising edge. The check runs before
    // the new prediction is queued so a word never matches itself.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_words
        body_word_t got;
        body_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {body_byte, body_valid, finished};
                words_out++;
                if (got.body_valid)
                    payload_seen++;
                if (decoded_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d with none pending: byte %02h vld %0b fin %0b",
                                 words_out, got.body_byte, got.body_valid, got.finished);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (want != got)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("word %0d: want %02h/%0b/%0b got %02h/%0b/%0b",
                                     words_out, want.body_byte, want.body_valid,
                                     want.finished, got.body_byte, got.body_valid,
                                     got.finished);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                chunked_on = cfg_data;
            if (in_valid && in_ready)
            begin
                decoded_q.push_back(decode_byte(in_byte));
                words_in++;
            end
        end
    end

    // Watchdog: too many cycles in a row with no handshake on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d words pending", stall_cycles,
                     decoded_q.size());
            $display("[http_chunked_body_decoder] ERROR");
            $finish;
        end
    end

    // Sink: random backpressure, none during the steady stretch.
    always @(negedge clk)
        out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // ------------------------------------------------------------------
    // Drivers. Everything here starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Send one byte; valid stays up on return so back-to-back words need
    // no low cycle in between.
    task automatic send_word(input logic [7:0] b);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        in_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        sent_words++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i]);
    endtask

    // Hold off the input until every decoded word has come back.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_mode(input logic m);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        mode_writes++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + {4'h0, nib};
        return (upper ? "A" : "a") + {4'h0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] blank_pick();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = CH_SP;
            1: c = CH_HT;
            2: c = CH_VT;
            default: c = CH_FF;
        endcase
        return c;
    endfunction

    // First character after the digits: a usual marker or any non-hex byte but CR or LF.
    function automatic logic [7:0] stop_char();
        string      marks;
        logic [7:0] c;
        logic [4:0] hx;
        marks = "x+-; ";
        if ($urandom_range(0, 1) == 1)
            return marks[$urandom_range(0, 4)];
        do
        begin
            c  = 8'($urandom);
            hx = hex_of(c);
        end
        while (!hx[4] || (c == CH_LF) || (c == CH_CR));
        return c;
    endfunction

    // Anything but LF can sit in the tail of a size line.
    function automatic logic [7:0] line_filler();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CH_LF);
        return c;
    endfunction

    // Bytes between chunks: usually CRLF, sometimes odd mixes or nothing.
    task automatic send_gap();
        if ($urandom_range(0, 9) < 6)
        begin
            send_word(CH_CR);
            send_word(CH_LF);
            gap_words += 2;
        end
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                send_word(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
                gap_words++;
            end
        end
    endtask

    // Size line for a nonzero size with random framing. Leading zeros are sent
    // only when no long blank run comes first; after a long run the first counted
    // non-blank is a nonzero digit, so the line never reads as the last chunk.
    task automatic send_size_line(input logic [SIZE_BITS-1:0] size);
        int nd;
        int blanks;
        nd = 1;
        while ((nd < SIZE_BITS / 4) && ((size >> (4 * nd)) != '0))
            nd++;
        case ($urandom_range(0, 9))
            0: blanks = (nd <= 2) ? 29 + $urandom_range(0, 1) : 0;
            1, 2, 3: blanks = $urandom_range(1, 3);
            default: blanks = 0;
        endcase
        repeat (blanks) send_word(blank_pick());
        if (blanks < 29)
            repeat ($urandom_range(0, 2)) send_word("0");
        for (int k = nd - 1; k >= 0; k--)
        begin
            send_word(digit_char(size[4*k +: 4], $urandom_range(0, 1) == 1));
            if ($urandom_range(0, 9) == 0)
                send_word(CH_CR);   // CR inside the digits is dropped
        end
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                send_word(stop_char());
                repeat ($urandom_range(0, 6)) send_word(line_filler());
            end
            3:
            begin
                // long extension, runs past the parsed part of the line
                send_word(";");
                repeat ($urandom_range(30, 40)) send_word(line_filler());
            end
            default: ;
        endcase
        if ($urandom_range(0, 9) < 7)
            send_word(CH_CR);
        send_word(CH_LF);
        chunks_sent++;
    endtask

    // Payload of the current chunk, as many bytes as are left in it.
    task automatic send_payload();
        logic [SIZE_BITS-1:0] n;
        n = chunk_left;
        repeat (n) send_word(8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Mode 0 after reset: every byte, framing ones too, is body.
    task automatic test_passthrough();
        send_word(8'h00);
        send_word(8'hFF);
        send_word(CH_LF);
        send_word(CH_CR);
        send_text("0");
    endtask

    // Framing basics: skipped CRLF, all four blanks, CR inside the digits,
    // a stop marker with a digit after it, and payload that looks like
    // framing.
    task automatic test_framing();
        send_word(CH_CR);
        send_word(CH_LF);
        send_word(CH_SP);
        send_word(CH_HT);
        send_word(CH_VT);
        send_word(CH_FF);
        send_text("0");
        send_word(CH_CR);
        send_text("2xA");
        send_word(CH_CR);
        send_word(CH_LF);
        send_word(CH_LF);
        send_text("0");
        chunks_sent++;
    endtask

    // Mostly well-formed chunks with random framing and content.
    task automatic test_random_chunks();
        int                   base;
        int                   pick;
        int                   done_items;
        logic [SIZE_BITS-1:0] size;
        base       = sent_words - gap_words;
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            // one long stretch with no idling on either side
            steady = (done_items >= 150) && (done_items < 260);
            send_gap();
            pick = $urandom_range(0, 99);
            if (pick < 80)
                size = $urandom_range(1, 8);
            else if (pick < 97)
                size = $urandom_range(9, 48);
            else
                size = $urandom_range(49, 300);
            send_size_line(size);
            send_payload();
            if ((chunks_sent == 12) || ($urandom_range(0, 39) == 0))
                wait_drained();
            done_items = sent_words - gap_words - base;
        end
        steady = 1'b0;
    endtask

    // Pass-through in the middle of a chunk must leave the chunk alone.
    task automatic test_mode_switch();
        send_gap();
        send_size_line(9);
        repeat (4) send_word(8'($urandom));
        set_mode(MODE_PASS);
        send_word(CH_LF);
        send_text("0");
        repeat (6) send_word(8'($urandom));
        set_mode(MODE_CHUNKED);
        send_payload();
    endtask

    // Both ways out of the body are terminal, so one run takes one of them:
    // the zero-size last chunk, or a size that saturates and never ends.
    task automatic test_ending();
        string forms[6];
        forms = '{"0\r\n", "0x1A\r\n", "+7\n", "-3\r\n", " \t\r\n", "000;name=val\r\n"};
        send_word(CH_CR);
        send_word(CH_LF);
        if ($urandom_range(0, 1) == 1)
        begin
            ending = "zero-size last chunk";
            send_text(forms[$urandom_range(0, 5)]);
            repeat (12) send_word(8'($urandom));   // all ignored now
        end
        else
        begin
            ending = "saturated chunk size";
            send_text("1");
            repeat ($urandom_range(8, 12))
                send_word(digit_char(4'($urandom), $urandom_range(0, 1) == 1));
            send_word(CH_CR);
            send_word(CH_LF);
            repeat (30) send_word(8'($urandom));   // CR/LF are payload here
        end
        set_mode(MODE_PASS);
        repeat (8) send_word(8'($urandom));
        set_mode(MODE_CHUNKED);
        repeat (6) send_word(8'($urandom));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_passthrough();
        set_mode(MODE_CHUNKED);
        test_framing();
        test_random_chunks();
        test_mode_switch();
        test_ending();
        wait_drained();

        $display("covered %0d words in, %0d payload words out, %0d chunks, %0d mode writes",
                 words_in, payload_seen, chunks_sent, mode_writes);
        $display("body ended by: %s; mismatches: %0d", ending, mismatches);
        if ((mismatches == 0) && (decoded_q.size() == 0))
        begin
            $display("[http_chunked_body_decoder] OK");
        end
        else
        begin
            $display("[http_chunked_body_decoder] ERROR");
        end
        $finish;
    end

endmodule
